// ===== hw/rtl/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpr_pkg: shared types and constants of the wrapping phase ramp
// Widths of the Q16.16 datapath, register indexes, controller states and the
// request and response words of the serial divider and multiplier.
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TRIG_BITS = 16;

  localparam int LVL_W   = 32;
  localparam int RATE_W  = 32;
  localparam int TRIG_W  = TRIG_BITS;
  localparam int FRAC_W  = FRAC_BITS + 1;
  localparam int DEN_W   = TRIG_W + 1;
  localparam int PROD_W  = RATE_W + 1;
  localparam int LOAD_W  = LVL_W + 2;
  localparam int SUM_W   = LOAD_W + 1;
  localparam int DIFF_W  = SUM_W + 1;
  localparam int SPAN_W  = LVL_W + 1;
  localparam int REM_W   = SPAN_W + 1;

  localparam int DIV_N_W   = DIFF_W;
  localparam int DIV_R_W   = SPAN_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
  localparam int MUL_CNT_W = $clog2(FRAC_BITS + 1);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [LVL_W-1:0] RANGE_START_RST = 32'h0000_0000;
  localparam logic [LVL_W-1:0] RANGE_END_RST   = 32'h0001_0000;
  localparam logic [LVL_W-1:0] RESET_POS_RST   = 32'h0000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RANGE_START = 2'd0,
    REG_RANGE_END   = 2'd1,
    REG_RESET_POS   = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MUL,
    S_SHOW,
    S_DIFF,
    S_MOD,
    S_MWAIT,
    S_FIX,
    S_STORE
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_R_W-1:0]   rem_init;
    logic [DIV_N_W-1:0]   num;
    logic [DIV_R_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_R_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [FRAC_W-1:0] frac;
    logic [RATE_W-1:0] rate;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== hw/rtl/rpr_divider.sv =====
// ----------------------------------------------------------------------------
// rpr_divider: serial restoring divider
// Produces one quotient bit per cycle for a programmable number of steps,
// starting from a preloaded partial remainder.
// ----------------------------------------------------------------------------
module rpr_divider import rpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_R_W-1:0]   rem_q, rem_d;
  logic [DIV_N_W-1:0]   num_q, num_d;
  logic [DIV_R_W-1:0]   den_q, den_d;

  logic [DIV_R_W:0] shifted;
  logic [DIV_R_W:0] diff;
  logic             fits;

  assign shifted = {rem_q, num_q[DIV_N_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      num_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_R_W-1:0] : shifted[DIV_R_W-1:0];
      num_d = {num_q[DIV_N_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/rpr_multiplier.sv =====
// ----------------------------------------------------------------------------
// rpr_multiplier: serial fraction by rate multiplier
// Scales the signed rate by an unsigned fraction in (0, 1], one fraction bit
// per cycle, rounding towards minus infinity.
// ----------------------------------------------------------------------------
module rpr_multiplier import rpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic [RATE_W-1:0]    rate_q, rate_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;

  logic signed [PROD_W:0] sum;

  assign sum = (PROD_W + 1)'(acc_q)
             + (frac_q[0] ? (PROD_W + 1)'($signed(rate_q)) : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    frac_d = frac_q;
    rate_d = rate_q;
    acc_d  = acc_q;
    if (req_i.start && !busy_q) begin
      rate_d = req_i.rate;
      if (req_i.frac[FRAC_BITS]) begin
        acc_d  = PROD_W'($signed(req_i.rate));
        done_d = 1'b1;
      end else begin
        acc_d  = '0;
        frac_d = req_i.frac[FRAC_BITS-1:0];
        cnt_d  = MUL_CNT_W'(FRAC_BITS);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      acc_d  = sum[PROD_W:1];
      frac_d = frac_q >> 1;
      cnt_d  = cnt_q - MUL_CNT_W'(1);
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
    rate_q <= rate_d;
    acc_q  <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

// ===== hw/rtl/wrapping_phase_ramp.sv =====
// ----------------------------------------------------------------------------
// wrapping_phase_ramp: phase ramp with trigger restart and range wrap
// A word without a trigger crossing starts from the stored level; a crossing runs
// the division, then the 16-step multiplication, which a fraction of one skips
// when the previous trigger was zero. The phase word is shown before the 36-step
// wrap division, which dominates; an empty range skips it. Stalls on the phase
// output hold the controller in S_SHOW; no new word is taken before the level is stored.
// Reset clears the level and the trigger history and resets the registers at once.
// ----------------------------------------------------------------------------
module wrapping_phase_ramp import rpr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TRIG_W-1:0]     trigger_i,
  input  logic [RATE_W-1:0]     rate_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LVL_W-1:0]      phase_o
);

  state_e state_q, state_d;

  logic [LVL_W-1:0] range_start_q, range_end_q, reset_pos_q;
  logic             wr_en;
  reg_idx_e         reg_idx;

  logic              primed_q, primed_d;
  logic [TRIG_W-1:0] prev_q, prev_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic              out_valid_q, out_valid_d;
  logic [LVL_W-1:0]  phase_q, phase_d;

  logic signed [TRIG_W-1:0] cur_q, cur_d;
  logic signed [RATE_W-1:0] rate_q, rate_d;
  logic signed [LOAD_W-1:0] lvl_q, lvl_d;
  logic signed [SUM_W-1:0]  x_q, x_d;
  logic signed [SPAN_W-1:0] span_q, span_d;
  logic signed [DIFF_W-1:0] dlt_q, dlt_d;
  logic signed [REM_W-1:0]  r_q, r_d;

  logic              fire;
  logic [DEN_W-1:0]  den;
  logic signed [REM_W-1:0] mag;
  logic [LVL_W:0]    store_sum;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  function automatic logic [LVL_W-1:0] saturate(input logic signed [LOAD_W-1:0] v);
    logic [LVL_W-1:0] res;
    if (v > LOAD_W'(signed'({1'b0, {(LVL_W - 1){1'b1}}}))) begin
      res = {1'b0, {(LVL_W - 1){1'b1}}};
    end else if (v < LOAD_W'(signed'({1'b1, {(LVL_W - 1){1'b0}}}))) begin
      res = {1'b1, {(LVL_W - 1){1'b0}}};
    end else begin
      res = v[LVL_W-1:0];
    end
    return res;
  endfunction

  // Configuration registers
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    unique case (reg_idx)
      REG_RANGE_START: prdata = range_start_q;
      REG_RANGE_END:   prdata = range_end_q;
      REG_RESET_POS:   prdata = reset_pos_q;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= RANGE_START_RST;
      range_end_q   <= RANGE_END_RST;
      reset_pos_q   <= RESET_POS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RANGE_START: range_start_q <= pwdata;
        REG_RANGE_END:   range_end_q   <= pwdata;
        REG_RESET_POS:   reset_pos_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // Controller
  assign fire = primed_q && ($signed(prev_q) <= 0) && (cur_q > 0);
  assign den  = DEN_W'(cur_q) - DEN_W'($signed(prev_q));
  assign mag  = $signed({1'b0, div_rsp.rem});
  assign store_sum = (LVL_W + 1)'($signed(range_start_q)) + (LVL_W + 1)'(r_q);

  always_comb begin
    state_d     = state_q;
    primed_d    = primed_q;
    prev_d      = prev_q;
    level_d     = level_q;
    out_valid_d = out_valid_q && !out_ready_i;
    phase_d     = phase_q;
    cur_d       = cur_q;
    rate_d      = rate_q;
    lvl_d       = lvl_q;
    x_d         = x_q;
    span_d      = span_q;
    dlt_d       = dlt_q;
    r_d         = r_q;
    div_req     = '0;
    mul_req     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d   = trigger_i;
          rate_d  = rate_i;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        prev_d   = cur_q;
        primed_d = 1'b1;
        if (fire) begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV_CNT_W'(FRAC_W);
          div_req.rem_init = DIV_R_W'(cur_q[TRIG_W-1:1]);
          div_req.num      = {cur_q[0], {(DIV_N_W - 1){1'b0}}};
          div_req.den      = DIV_R_W'(den);
          state_d          = S_DIV;
        end else begin
          lvl_d   = LOAD_W'($signed(level_q));
          state_d = S_SHOW;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.frac  = div_rsp.quot[FRAC_W-1:0];
          mul_req.rate  = rate_q;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_rsp.done) begin
          lvl_d   = LOAD_W'($signed(reset_pos_q)) + LOAD_W'($signed(mul_rsp.prod));
          state_d = S_SHOW;
        end
      end
      S_SHOW: begin
        if (!out_valid_q || out_ready_i) begin
          phase_d     = saturate(lvl_q);
          out_valid_d = 1'b1;
          x_d         = SUM_W'(lvl_q) + SUM_W'(rate_q);
          span_d      = SPAN_W'($signed(range_end_q)) - SPAN_W'($signed(range_start_q));
          state_d     = S_DIFF;
        end
      end
      S_DIFF: begin
        dlt_d   = DIFF_W'(x_q) - DIFF_W'($signed(range_start_q));
        state_d = S_MOD;
      end
      S_MOD: begin
        if (span_q == '0) begin
          level_d = range_start_q;
          state_d = S_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV_CNT_W'(DIV_N_W);
          div_req.rem_init = '0;
          div_req.num      = dlt_q[DIFF_W-1] ? DIV_N_W'(-dlt_q) : DIV_N_W'(dlt_q);
          div_req.den      = span_q[SPAN_W-1] ? DIV_R_W'(-span_q) : DIV_R_W'(span_q);
          state_d          = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (div_rsp.done) begin
          r_d     = dlt_q[DIFF_W-1] ? -mag : mag;
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if ((dlt_q[DIFF_W-1] != span_q[SPAN_W-1]) && (r_q != '0)) begin
          r_d = r_q + REM_W'(span_q);
        end
        state_d = S_STORE;
      end
      S_STORE: begin
        level_d = store_sum[LVL_W-1:0];
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      primed_q    <= 1'b0;
      prev_q      <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      prev_q      <= prev_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    cur_q   <= cur_d;
    rate_q  <= rate_d;
    lvl_q   <= lvl_d;
    x_q     <= x_d;
    span_q  <= span_d;
    dlt_q   <= dlt_d;
    r_q     <= r_d;
  end

  rpr_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rpr_multiplier u_multiplier (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign phase_o     = phase_q;

endmodule
